>>> rtl/tile_dequant_inverse_dwt_assert.svh
// Assertion macros shared by the tile dequantiser and inverse wavelet RTL.
`ifndef TILE_DEQUANT_INVERSE_DWT_ASSERT_SVH
`define TILE_DEQUANT_INVERSE_DWT_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TDIDWT_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tdidwt assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define TDIDWT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tdidwt assertion failed");

`endif

>>> rtl/tdidwt_pkg.sv
// Package with the operation codes, constants and arithmetic helpers of the tile transform.
package tdidwt_pkg;

  localparam int unsigned CoeffWidth = 16;
  localparam int unsigned AddrWidth  = 12;
  localparam int unsigned TileDepth  = 4096;
  localparam int unsigned QuantWidth = 40;

  localparam logic [1:0] OP_WRITE     = 2'd0;
  localparam logic [1:0] OP_TRANSFORM = 2'd1;
  localparam logic [1:0] OP_READ      = 2'd2;

  localparam logic [QuantWidth-1:0] QuantReset = 40'h6666666666;

  typedef logic [CoeffWidth-1:0] coeff_t;
  typedef logic [AddrWidth-1:0]  addr_t;

  function automatic coeff_t asr1(input coeff_t x);
    asr1 = {x[CoeffWidth-1], x[CoeffWidth-1:1]};
  endfunction

  function automatic logic [3:0] band_nibble(input addr_t a);
    logic [3:0] n;
    if (a < 12'd1024) begin
      n = 4'd8;
    end else if (a < 12'd2048) begin
      n = 4'd7;
    end else if (a < 12'd3072) begin
      n = 4'd9;
    end else if (a < 12'd3328) begin
      n = 4'd5;
    end else if (a < 12'd3584) begin
      n = 4'd4;
    end else if (a < 12'd3840) begin
      n = 4'd6;
    end else if (a < 12'd3904) begin
      n = 4'd2;
    end else if (a < 12'd3968) begin
      n = 4'd1;
    end else if (a < 12'd4032) begin
      n = 4'd3;
    end else begin
      n = 4'd0;
    end
    band_nibble = n;
  endfunction

  function automatic coeff_t dequant(input coeff_t x, input logic [3:0] q);
    coeff_t r;
    if (q == 4'd0) begin
      r = asr1(x);
    end else begin
      r = x << (q - 4'd1);
    end
    dequant = r;
  endfunction

endpackage

>>> rtl/tdidwt_ram.sv
// Generic single write port, single read port RAM with a registered read.
module tdidwt_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/tile_dequant_inverse_dwt.sv
// Top level of the tile dequantiser and three-level inverse 5/3 wavelet transform.
// A write is stored in the cycle it is accepted; a read result appears in the cycle after its transfer.
// A transform performs each memory update as up to three operand reads through the registered
// read ports, then one write-back.
// Reset clears the control state and loads the quant register; the tile memories are not cleared.
`include "tile_dequant_inverse_dwt_assert.svh"
module tile_dequant_inverse_dwt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [39:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // index [11:0], coefficient [27:12], zero fill
  input  logic [1:0]  s_axis_tuser,  // opcode [1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // sample [15:0]
  output logic        m_axis_tuser   // is_done [0]
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_DEQ  = 3'd1;
  localparam logic [2:0] PH_ROWL = 3'd2;
  localparam logic [2:0] PH_ROWC = 3'd3;
  localparam logic [2:0] PH_ROWH = 3'd4;
  localparam logic [2:0] PH_COLL = 3'd5;
  localparam logic [2:0] PH_COLH = 3'd6;

  logic [2:0]  phase_q, phase_d;
  logic [1:0]  lv_q, lv_d;
  logic        pass_q, pass_d;
  logic [5:0]  o_q, o_d, i_q, i_d;
  logic [1:0]  st_q, st_d;
  logic        sc_q;
  logic        rd_pend_q, rd_pend_d;
  logic        done_q, done_d;
  logic [39:0] quant_q;
  tdidwt_pkg::coeff_t opa_q, opb_q;

  logic        in_acc, out_acc, busy;
  logic [1:0]  op;
  logic [2:0]  lw;
  logic [5:0]  w_m1, lim_i, lim_o, ip1, im1, op1, om1;
  tdidwt_pkg::addr_t base, ww, lo, ho, dofs, o12, i12, rowb;
  tdidwt_pkg::addr_t addr_a, addr_b, addr_c, addr_w, cur_addr;
  logic        sc_a, sc_b, sc_c, sc_w, cur_sc;
  tdidwt_pkg::coeff_t tile_rdata, scr_rdata, rdata, result;
  logic        tile_we, tile_re, scr_we, scr_re;
  tdidwt_pkg::addr_t tile_waddr, tile_raddr;
  tdidwt_pkg::coeff_t tile_wdata;

  assign op      = s_axis_tuser;
  assign busy    = (phase_q != PH_IDLE);
  assign m_axis_tvalid = rd_pend_q | done_q;
  assign m_axis_tdata  = done_q ? '0 : tile_rdata;
  assign m_axis_tuser  = done_q;
  assign s_axis_tready = !busy && (!m_axis_tvalid || m_axis_tready);
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_comb begin
    lw   = 3'd3 + {1'b0, lv_q};
    w_m1 = (6'd8 << lv_q) - 6'd1;
    unique case (lv_q)
      2'd0:    base = 12'd3840;
      2'd1:    base = 12'd3072;
      default: base = 12'd0;
    endcase
    ww   = 12'd1 << {lw, 1'b0};
    lo   = pass_q ? ww : ((ww << 1) + ww);
    ho   = pass_q ? (ww << 1) : 12'd0;
    dofs = pass_q ? (ww << 1) : 12'd0;
    o12  = {6'd0, o_q};
    i12  = {6'd0, i_q};
    ip1  = (i_q == w_m1) ? i_q : i_q + 6'd1;
    im1  = (i_q == 6'd0) ? i_q : i_q - 6'd1;
    op1  = (o_q == w_m1) ? o_q : o_q + 6'd1;
    om1  = (o_q == 6'd0) ? o_q : o_q - 6'd1;
    rowb = base + (o12 << lw);
    addr_a = '0;
    addr_b = '0;
    addr_c = '0;
    addr_w = '0;
    sc_a   = 1'b0;
    sc_b   = 1'b0;
    sc_c   = 1'b0;
    sc_w   = 1'b0;
    lim_i  = w_m1;
    lim_o  = w_m1;
    unique case (phase_q)
      PH_DEQ: begin
        addr_a = {o_q, i_q};
        addr_w = {o_q, i_q};
        lim_i  = 6'd63;
        lim_o  = 6'd63;
      end
      PH_ROWL: begin
        addr_a = rowb + lo + i12;
        addr_b = rowb + ho + i12;
        addr_c = rowb + ho + {6'd0, im1};
        addr_w = addr_a;
      end
      PH_ROWC: begin
        addr_a = rowb + lo + i12;
        addr_w = dofs + (o12 << (lw + 3'd1)) + (i12 << 1);
        sc_w   = 1'b1;
      end
      PH_ROWH: begin
        addr_a = rowb + lo + i12;
        addr_b = rowb + lo + {6'd0, ip1};
        addr_c = rowb + ho + i12;
        addr_w = dofs + (o12 << (lw + 3'd1)) + (i12 << 1) + 12'd1;
        sc_w   = 1'b1;
      end
      PH_COLL: begin
        addr_a = (o12 << (lw + 3'd1)) + i12;
        addr_b = (ww << 1) + (o12 << (lw + 3'd1)) + i12;
        addr_c = (ww << 1) + ({6'd0, om1} << (lw + 3'd1)) + i12;
        addr_w = base + (o12 << (lw + 3'd2)) + i12;
        sc_a   = 1'b1;
        sc_b   = 1'b1;
        sc_c   = 1'b1;
        lim_i  = {w_m1[4:0], 1'b1};
      end
      PH_COLH: begin
        addr_a = base + (o12 << (lw + 3'd2)) + i12;
        addr_b = base + ({6'd0, op1} << (lw + 3'd2)) + i12;
        addr_c = (ww << 1) + (o12 << (lw + 3'd1)) + i12;
        addr_w = addr_a + (12'd1 << (lw + 3'd1));
        sc_c   = 1'b1;
        lim_i  = {w_m1[4:0], 1'b1};
      end
      default: begin
        addr_a = '0;
      end
    endcase
  end

  always_comb begin
    unique case (st_q)
      2'd0: begin
        cur_addr = addr_a;
        cur_sc   = sc_a;
      end
      2'd1: begin
        cur_addr = addr_b;
        cur_sc   = sc_b;
      end
      default: begin
        cur_addr = addr_c;
        cur_sc   = sc_c;
      end
    endcase
  end

  assign rdata = sc_q ? scr_rdata : tile_rdata;

  always_comb begin
    case (phase_q)
      PH_DEQ:  result = tdidwt_pkg::dequant(opa_q,
                          quant_q[{tdidwt_pkg::band_nibble(addr_w), 2'b00} +: 4]);
      PH_ROWC: result = opa_q;
      PH_ROWH, PH_COLH: begin
        result = tdidwt_pkg::asr1(opa_q + opb_q) + {rdata[14:0], 1'b0};
      end
      default: result = opa_q - tdidwt_pkg::asr1(opb_q + rdata + 16'd1);
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    lv_d      = lv_q;
    pass_d    = pass_q;
    o_d       = o_q;
    i_d       = i_q;
    st_d      = busy ? st_q + 2'd1 : 2'd0;
    done_d    = done_q;
    rd_pend_d = rd_pend_q;
    if (out_acc) begin
      done_d    = 1'b0;
      rd_pend_d = 1'b0;
    end
    if (in_acc && op == tdidwt_pkg::OP_READ) begin
      rd_pend_d = 1'b1;
    end
    if (in_acc && op == tdidwt_pkg::OP_TRANSFORM) begin
      phase_d = PH_DEQ;
      lv_d    = 2'd0;
      pass_d  = 1'b0;
      o_d     = '0;
      i_d     = '0;
    end
    if (busy && st_q == 2'd3) begin
      if (i_q != lim_i) begin
        i_d = i_q + 6'd1;
      end else begin
        i_d = '0;
        if (o_q != lim_o) begin
          o_d = o_q + 6'd1;
        end else begin
          o_d = '0;
          unique case (phase_q)
            PH_DEQ: begin
              phase_d = PH_ROWL;
              pass_d  = 1'b0;
            end
            PH_ROWL, PH_ROWC, PH_ROWH: begin
              pass_d = !pass_q;
              if (pass_q) begin
                phase_d = phase_q + 3'd1;
              end
            end
            PH_COLL: phase_d = PH_COLH;
            PH_COLH: begin
              if (lv_q == 2'd2) begin
                phase_d = PH_IDLE;
                done_d  = 1'b1;
              end else begin
                lv_d    = lv_q + 2'd1;
                phase_d = PH_ROWL;
              end
            end
            default: phase_d = PH_IDLE;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      lv_q      <= '0;
      pass_q    <= 1'b0;
      o_q       <= '0;
      i_q       <= '0;
      st_q      <= '0;
      sc_q      <= 1'b0;
      rd_pend_q <= 1'b0;
      done_q    <= 1'b0;
      quant_q   <= tdidwt_pkg::QuantReset;
    end else begin
      phase_q   <= phase_d;
      lv_q      <= lv_d;
      pass_q    <= pass_d;
      o_q       <= o_d;
      i_q       <= i_d;
      st_q      <= st_d;
      sc_q      <= cur_sc;
      rd_pend_q <= rd_pend_d;
      done_q    <= done_d;
      if (cfg_we_i) begin
        quant_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == 2'd1) begin
      opa_q <= rdata;
    end
    if (st_q == 2'd2) begin
      opb_q <= rdata;
    end
  end

  assign tile_we    = (in_acc && op == tdidwt_pkg::OP_WRITE) || (busy && st_q == 2'd3 && !sc_w);
  assign tile_waddr = busy ? addr_w : s_axis_tdata[11:0];
  assign tile_wdata = busy ? result : s_axis_tdata[27:12];
  assign tile_re    = (in_acc && op == tdidwt_pkg::OP_READ) || (busy && st_q != 2'd3);
  assign tile_raddr = busy ? cur_addr : s_axis_tdata[11:0];
  assign scr_we     = busy && st_q == 2'd3 && sc_w;
  assign scr_re     = busy && st_q != 2'd3;

  tdidwt_ram #(
    .WIDTH(tdidwt_pkg::CoeffWidth),
    .DEPTH(tdidwt_pkg::TileDepth)
  ) u_tile_ram (
    .clk_i   (clk_i),
    .we_i    (tile_we),
    .waddr_i (tile_waddr),
    .wdata_i (tile_wdata),
    .re_i    (tile_re),
    .raddr_i (tile_raddr),
    .rdata_o (tile_rdata)
  );

  tdidwt_ram #(
    .WIDTH(tdidwt_pkg::CoeffWidth),
    .DEPTH(tdidwt_pkg::TileDepth)
  ) u_scratch_ram (
    .clk_i   (clk_i),
    .we_i    (scr_we),
    .waddr_i (addr_w),
    .wdata_i (result),
    .re_i    (scr_re),
    .raddr_i (cur_addr),
    .rdata_o (scr_rdata)
  );

  `TDIDWT_ASSERT_SAME(a_no_accept_busy, clk_i, rst_ni, busy, !s_axis_tready)
  `TDIDWT_ASSERT_SAME(a_one_result_kind, clk_i, rst_ni, done_q, !rd_pend_q)
  `TDIDWT_ASSERT_SAME(a_done_after_cols, clk_i, rst_ni, $rose(done_q), $past(phase_q) == PH_COLH)
  `TDIDWT_ASSERT_NEXT(a_transform_starts, clk_i, rst_ni,
                      in_acc && op == tdidwt_pkg::OP_TRANSFORM, phase_q == PH_DEQ)

endmodule
